// ===== hdl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types, constants and helper functions for the triangle LFO with
// rungler shift register.
// ----------------------------------------------------------------------------
package rsr_pkg;

   localparam int unsigned DataWidth  = 8;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [DataWidth-1:0]  RandomThresholdReset = 8'd162;
   localparam logic [DataWidth-1:0]  InvertThresholdReset = 8'd150;
   localparam logic [DataWidth-1:0]  RunglerSeedReset     = 8'd0;
   localparam logic [CountWidth-1:0] EdgeCountMax         = 4'd15;
   localparam logic [CountWidth-1:0] SyncEdgeLimit        = 4'd4;
   localparam logic [CountWidth-1:0] EdgeDisableLimit     = 4'd8;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrRandomThreshold = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrInvertThreshold = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRunglerSeed     = 2'd2;

   // Function codes of an input transfer
   localparam logic FuncTick  = 1'b0;
   localparam logic FuncClock = 1'b1;

   typedef struct packed {
      logic                 func;
      logic                 clock_level;
      logic [DataWidth-1:0] bit_control;
      logic                 random_bit;
   } req_payload_type;

   typedef struct packed {
      logic [DataWidth-1:0] triangle_out;
      logic                 square_out;
      logic [DataWidth-1:0] stepped_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [DataWidth-1:0] random_threshold;
      logic [DataWidth-1:0] invert_threshold;
      logic                 seed_load;
      logic [DataWidth-1:0] seed_value;
   } csr_state_type;

   // Stepped voltage table indexed by shift register bits {5,3,0}
   function automatic logic [DataWidth-1:0] level_lookup(input logic [2:0] idx);
      logic [DataWidth-1:0] lvl;
      case (idx)
         3'd0:    lvl = 8'd0;
         3'd1:    lvl = 8'd80;
         3'd2:    lvl = 8'd120;
         3'd3:    lvl = 8'd150;
         3'd4:    lvl = 8'd180;
         3'd5:    lvl = 8'd200;
         3'd6:    lvl = 8'd220;
         3'd7:    lvl = 8'd255;
         default: lvl = 8'd0;
      endcase
      return lvl;
   endfunction

   // One rungler step: recirculate, invert or take the random bit
   function automatic logic [DataWidth-1:0] rungler_step(
      input logic [DataWidth-1:0] sreg,
      input logic [DataWidth-1:0] control,
      input logic                 rnd,
      input logic [DataWidth-1:0] rnd_thresh,
      input logic [DataWidth-1:0] inv_thresh
   );
      logic fresh;
      fresh = sreg[DataWidth-1];
      if (control > rnd_thresh) begin
         fresh = rnd;
      end else if (control >= inv_thresh) begin
         fresh = ~sreg[DataWidth-1];
      end
      return {sreg[DataWidth-2:0], fresh};
   endfunction

   function automatic logic [DataWidth-1:0] rungler_level(input logic [DataWidth-1:0] sreg);
      return level_lookup({sreg[5], sreg[3], sreg[0]});
   endfunction

endpackage

// ===== hdl/rsr_csr.sv =====
// ----------------------------------------------------------------------------
// rsr_csr
// Configuration registers: thresholds and rungler seed, with a seed load
// strobe for the shift register.
// ----------------------------------------------------------------------------
module rsr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rsr_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rsr_pkg::DataWidth-1:0]   csr_wdata,
   output rsr_pkg::csr_state_type          csr_state
);
   import rsr_pkg::*;

   logic [DataWidth-1:0] random_threshold_ff, random_threshold_in;
   logic [DataWidth-1:0] invert_threshold_ff, invert_threshold_in;
   logic [DataWidth-1:0] seed_ff, seed_in;

   always_comb begin
      random_threshold_in = random_threshold_ff;
      invert_threshold_in = invert_threshold_ff;
      seed_in             = seed_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CsrRandomThreshold: random_threshold_in = csr_wdata;
            CsrInvertThreshold: invert_threshold_in = csr_wdata;
            CsrRunglerSeed:     seed_in             = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         random_threshold_ff <= RandomThresholdReset;
         invert_threshold_ff <= InvertThresholdReset;
         seed_ff             <= RunglerSeedReset;
      end else begin
         random_threshold_ff <= random_threshold_in;
         invert_threshold_ff <= invert_threshold_in;
         seed_ff             <= seed_in;
      end
   end

   // Seed write also loads the shift register in the same edge, unless an item advances then
   assign csr_state.random_threshold = random_threshold_ff;
   assign csr_state.invert_threshold = invert_threshold_ff;
   assign csr_state.seed_load        = csr_wr_en && (csr_index == CsrRunglerSeed);
   assign csr_state.seed_value       = csr_wdata;

endmodule

// ===== hdl/rsr_core.sv =====
// ----------------------------------------------------------------------------
// rsr_core
// LFO phase, slope, sync and rungler state; computes the next state and the
// result of one item in a single pass.
// ----------------------------------------------------------------------------
module rsr_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_go,
   input  rsr_pkg::req_payload_type item,
   input  rsr_pkg::csr_state_type   csr_state,
   output rsr_pkg::rsp_payload_type result
);
   import rsr_pkg::*;

   logic [DataWidth-1:0]  phase_ff, phase_in;
   logic                  falling_ff, falling_in;
   logic [DataWidth-1:0]  triangle_ff, triangle_in;
   logic                  square_ff, square_in;
   logic                  last_clock_ff, last_clock_in;
   logic [CountWidth-1:0] edge_count_ff, edge_count_in;
   logic                  sync_ff, sync_in;
   logic [DataWidth-1:0]  shift_ff, shift_in;
   logic [DataWidth-1:0]  stepped_ff, stepped_in;

   logic                 rising;
   logic                 square_now;
   logic [DataWidth-1:0] shift_mid;
   logic [DataWidth-1:0] stepped_mid;

   always_comb begin
      phase_in      = phase_ff;
      falling_in    = falling_ff;
      triangle_in   = triangle_ff;
      last_clock_in = last_clock_ff;
      edge_count_in = edge_count_ff;
      sync_in       = sync_ff;
      rising        = 1'b0;

      if (item.func == FuncTick) begin
         phase_in = phase_ff + 1'b1;
         if (phase_in == '0) begin
            falling_in = ~falling_ff;
            if (falling_in) begin
               sync_in       = (edge_count_ff <= SyncEdgeLimit);
               edge_count_in = '0;
            end
         end
         triangle_in = falling_in ? ~phase_in : phase_in;
      end else begin
         rising = ~last_clock_ff & item.clock_level;
         if (rising) begin
            if (edge_count_ff < EdgeCountMax) begin
               edge_count_in = edge_count_ff + 1'b1;
            end
            if (edge_count_in > EdgeDisableLimit) begin
               sync_in = 1'b0;
            end
            if (sync_in) begin
               phase_in   = '0;
               falling_in = 1'b0;
            end
         end
         last_clock_in = item.clock_level;
      end

      // First step on a clock edge
      shift_mid   = shift_ff;
      stepped_mid = stepped_ff;
      if (rising) begin
         shift_mid   = rungler_step(shift_ff, item.bit_control, item.random_bit,
                                    csr_state.random_threshold,
                                    csr_state.invert_threshold);
         stepped_mid = rungler_level(shift_mid);
      end

      // Square change may step the rungler once more
      square_now = ~phase_in[DataWidth-1];
      square_in  = square_ff;
      shift_in   = shift_mid;
      stepped_in = stepped_mid;
      if (square_now != square_ff) begin
         square_in = square_now;
         if (sync_in) begin
            shift_in   = rungler_step(shift_mid, item.bit_control, item.random_bit,
                                      csr_state.random_threshold,
                                      csr_state.invert_threshold);
            stepped_in = rungler_level(shift_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         falling_ff    <= 1'b1;
         triangle_ff   <= '0;
         square_ff     <= 1'b0;
         last_clock_ff <= 1'b0;
         edge_count_ff <= '0;
         sync_ff       <= 1'b0;
         shift_ff      <= RunglerSeedReset;
         stepped_ff    <= '0;
      end else if (item_go) begin
         phase_ff      <= phase_in;
         falling_ff    <= falling_in;
         triangle_ff   <= triangle_in;
         square_ff     <= square_in;
         last_clock_ff <= last_clock_in;
         edge_count_ff <= edge_count_in;
         sync_ff       <= sync_in;
         shift_ff      <= shift_in;
         stepped_ff    <= stepped_in;
      end else if (csr_state.seed_load) begin
         shift_ff <= csr_state.seed_value;
      end
   end

   assign result.triangle_out = triangle_in;
   assign result.square_out   = square_in;
   assign result.stepped_out  = stepped_in;

endmodule

// ===== hdl/synced_triangle_lfo_with_rungler.sv =====
// ----------------------------------------------------------------------------
// synced_triangle_lfo_with_rungler
// Triangle/square LFO with clock sync and an 8-bit rungler shift register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: an LFO tick (func 0) or a sample of
//   the external clock pin (func 1) with the control level and random bit.
//   rsp_* returns exactly one result per item: triangle level, square level
//   and stepped rungler voltage, in item order.
//   csr_* writes the thresholds and the seed; a seed write loads the shift
//   register at once. Write only while no transfer is in flight.
// Path: each req item passes the input register, then the state update
//   that fills the result register; rsp_valid rises once that register
//   holds the result.
// Throughput: one item per cycle while rsp_stall is low; each item's whole
//   update is one pass of shallow logic between input and result register.
// Reset: synchronous, active high; empties both registers, loads the reset
//   register values and clears the LFO and rungler state (shift register to
//   the seed reset value).
// Stall: while rsp_stall holds a waiting result, the input register holds
//   its item and req_stall rises once that register is occupied.
// ----------------------------------------------------------------------------
module synced_triangle_lfo_with_rungler (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rsr_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rsr_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [rsr_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [rsr_pkg::DataWidth-1:0]   csr_wdata
);
   import rsr_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff;

   logic            out_free;
   logic            advance;
   logic            req_take;
   csr_state_type   csr_state;
   rsp_payload_type core_result;

   // Result register can take a new value when empty or being drained
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   rsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_state (csr_state)
   );

   rsr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_go   (advance),
      .item      (in_item_ff),
      .csr_state (csr_state),
      .result    (core_result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

// ===== tb/sv/tb_synced_triangle_lfo_with_rungler.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_synced_triangle_lfo_with_rungler
// Self-checking bench for the triangle LFO with clock sync and rungler. A
// short table of hand-picked transfers comes first. It is followed by phases
// of random tick and clock sequences, each under its own threshold and seed
// setting. Each result is checked against its typed value or an in-bench
// model of the LFO, the edge counter and the shift register.
// ----------------------------------------------------------------------------
module tb_synced_triangle_lfo_with_rungler;
   import rsr_pkg::*;

   localparam int unsigned ClockPeriod = 10;
   localparam int unsigned ResetCycles = 8;
   localparam int unsigned IdlePct     = 24;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned CycleLimit  = 300000;
   localparam logic [DataWidth-1:0] HalfScale = 8'd128;
   localparam logic [DataWidth-1:0] FullScale = 8'd255;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type result;
   } stim_row_type;

   typedef struct {
      logic [DataWidth-1:0] rnd_limit;
      logic [DataWidth-1:0] inv_limit;
      logic [DataWidth-1:0] seed;
      int unsigned          count;
      int unsigned          gap_lo;
      int unsigned          gap_hi;
      int unsigned          noise_pct;
      bit                   steady;
   } phase_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [DataWidth-1:0]   csr_wdata = '0;

   // Results still owed by the block, oldest first
   rsp_payload_type pending_results[$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;
   bit              steady_run = 1'b0;

   // Model state: configuration
   logic [DataWidth-1:0]  rnd_limit;
   logic [DataWidth-1:0]  inv_limit;
   // Model state: LFO, edge detector and rungler
   logic [DataWidth-1:0]  phase_acc;
   logic                  slope_down;
   logic [DataWidth-1:0]  tri_level;
   logic                  square_q;
   logic                  clk_seen;
   logic [CountWidth-1:0] edge_tally;
   logic                  sync_armed;
   logic [DataWidth-1:0]  rungler_bits;
   logic [DataWidth-1:0]  stepped_q;

   synced_triangle_lfo_with_rungler i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Watchdog: a correct run finishes far below this count
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side backpressure; held off entirely during a steady stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady_run && ($urandom_range(99) < IdlePct);
      end
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------
   function automatic logic [DataWidth-1:0] level_of(input logic [2:0] sel);
      case (sel)
         3'd0:    return 8'd0;
         3'd1:    return 8'd80;
         3'd2:    return 8'd120;
         3'd3:    return 8'd150;
         3'd4:    return 8'd180;
         3'd5:    return 8'd200;
         3'd6:    return 8'd220;
         default: return 8'd255;
      endcase
   endfunction

   function automatic void clear_model();
      rnd_limit    = RandomThresholdReset;
      inv_limit    = InvertThresholdReset;
      phase_acc    = '0;
      slope_down   = 1'b1;
      tri_level    = '0;
      square_q     = 1'b0;
      clk_seen     = 1'b0;
      edge_tally   = '0;
      sync_armed   = 1'b0;
      rungler_bits = RunglerSeedReset;
      stepped_q    = '0;
   endfunction

   // Shift once: the random test wins over the invert test, even when the
   // thresholds cross
   function automatic void advance_rungler(input logic [DataWidth-1:0] control,
                                           input logic rnd);
      logic fresh;
      fresh = rungler_bits[DataWidth-1];
      if (control > rnd_limit) begin
         fresh = rnd;
      end else if (control >= inv_limit) begin
         fresh = ~rungler_bits[DataWidth-1];
      end
      rungler_bits = {rungler_bits[DataWidth-2:0], fresh};
      stepped_q = level_of({rungler_bits[5], rungler_bits[3], rungler_bits[0]});
   endfunction

   function automatic rsp_payload_type lfo_rungler_response(input req_payload_type item);
      rsp_payload_type res;
      logic            sq;
      if (item.func == FuncTick) begin
         phase_acc = phase_acc + 8'd1;
         if (phase_acc == '0) begin
            slope_down = ~slope_down;
            // Start of a falling half: judge the edge rate of the last period
            if (slope_down) begin
               sync_armed = (edge_tally <= SyncEdgeLimit);
               edge_tally = '0;
            end
         end
         tri_level = slope_down ? FullScale - phase_acc : phase_acc;
      end else begin
         if (!clk_seen && item.clock_level) begin
            if (edge_tally < EdgeCountMax) begin
               edge_tally = edge_tally + 4'd1;
            end
            if (edge_tally > EdgeDisableLimit) begin
               sync_armed = 1'b0;
            end
            // Sync restarts the phase; the triangle level waits for a tick
            if (sync_armed) begin
               phase_acc  = '0;
               slope_down = 1'b0;
            end
            advance_rungler(item.bit_control, item.random_bit);
         end
         clk_seen = item.clock_level;
      end
      // A square change with sync armed shifts the rungler again
      sq = (phase_acc < HalfScale);
      if (sq != square_q) begin
         square_q = sq;
         if (sync_armed) begin
            advance_rungler(item.bit_control, item.random_bit);
         end
      end
      res.triangle_out = tri_level;
      res.square_out   = square_q;
      res.stepped_out  = stepped_q;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: triangle_out %0d square_out %0d stepped_out %0d",
                   rsp_payload.triangle_out, rsp_payload.square_out,
                   rsp_payload.stepped_out);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.triangle_out !== want.triangle_out) begin
               $error("triangle_out: expected %0d, actual %0d",
                      want.triangle_out, rsp_payload.triangle_out);
               mismatch_count++;
            end
            if (rsp_payload.square_out !== want.square_out) begin
               $error("square_out: expected %0d, actual %0d",
                      want.square_out, rsp_payload.square_out);
               mismatch_count++;
            end
            if (rsp_payload.stepped_out !== want.stepped_out) begin
               $error("stepped_out: expected %0d, actual %0d",
                      want.stepped_out, rsp_payload.stepped_out);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Offer one transfer, idling at random first; book its expected result once
   // it is taken. A typed result, where given, stands in for the model's.
   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type typed_res);
      rsp_payload_type res;
      while (!steady_run && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = lfo_rungler_response(item);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   // Drop valid and let every owed result come back before touching registers
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_phase(input phase_type ph);
      csr_wr_en <= 1'b1;
      csr_index <= CsrRandomThreshold;
      csr_wdata <= ph.rnd_limit;
      @(posedge clock);
      rnd_limit = ph.rnd_limit;
      csr_index <= CsrInvertThreshold;
      csr_wdata <= ph.inv_limit;
      @(posedge clock);
      inv_limit = ph.inv_limit;
      csr_index <= CsrRunglerSeed;
      csr_wdata <= ph.seed;
      @(posedge clock);
      // A seed write loads the shift register at once
      rungler_bits = ph.seed;
      csr_wr_en <= 1'b0;
   endtask

   // Favor control levels right at the thresholds
   function automatic logic [DataWidth-1:0] pick_control();
      case ($urandom_range(5))
         0:       return rnd_limit;
         1:       return rnd_limit + 8'd1;
         2:       return inv_limit;
         3:       return inv_limit - 8'd1;
         default: return DataWidth'($urandom);
      endcase
   endfunction

   function automatic stim_row_type mk_row(input logic func, input logic clk_lvl,
                                           input logic [DataWidth-1:0] ctl,
                                           input logic rnd, input bit typed,
                                           input logic [DataWidth-1:0] tri_v,
                                           input logic sq_v,
                                           input logic [DataWidth-1:0] step_v);
      stim_row_type row;
      row.item.func           = func;
      row.item.clock_level    = clk_lvl;
      row.item.bit_control    = ctl;
      row.item.random_bit     = rnd;
      row.typed               = typed;
      row.result.triangle_out = tri_v;
      row.result.square_out   = sq_v;
      row.result.stepped_out  = step_v;
      return row;
   endfunction

   function automatic phase_type mk_phase(input logic [DataWidth-1:0] rnd_l,
                                          input logic [DataWidth-1:0] inv_l,
                                          input logic [DataWidth-1:0] seed,
                                          input int unsigned count,
                                          input int unsigned gap_lo,
                                          input int unsigned gap_hi,
                                          input int unsigned noise_pct,
                                          input bit steady);
      phase_type ph;
      ph.rnd_limit = rnd_l;
      ph.inv_limit = inv_l;
      ph.seed      = seed;
      ph.count     = count;
      ph.gap_lo    = gap_lo;
      ph.gap_hi    = gap_hi;
      ph.noise_pct = noise_pct;
      ph.steady    = steady;
      return ph;
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      stim_row_type    dir_rows[$];
      phase_type       phases[$];
      req_payload_type item;
      rsp_payload_type no_result;
      int unsigned     ticks_left;
      bit              rise_next;

      no_result = '0;

      // Directed rows run at the reset register values. Their rising edges number
      // SyncEdgeLimit, the most that still arms sync at the second wrap.
      dir_rows.push_back(mk_row(FuncTick,  1'b0, 8'd0,   1'b0, 1'b1, 8'd254, 1'b1, 8'd0));
      // Tick with the clock pin high: the pin is ignored
      dir_rows.push_back(mk_row(FuncTick,  1'b1, 8'd255, 1'b1, 1'b1, 8'd253, 1'b1, 8'd0));
      // Rising edge, control above the random threshold: take the random bit
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd255, 1'b1, 1'b1, 8'd253, 1'b1, 8'd80));
      // Pin held high: no edge, nothing moves
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd255, 1'b0, 1'b1, 8'd253, 1'b1, 8'd80));
      dir_rows.push_back(mk_row(FuncClock, 1'b0, 8'd0,   1'b1, 1'b1, 8'd253, 1'b1, 8'd80));
      // Control equal to the random threshold falls into the invert band
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd162, 1'b0, 1'b1, 8'd253, 1'b1, 8'd80));
      dir_rows.push_back(mk_row(FuncClock, 1'b0, 8'd149, 1'b0, 1'b1, 8'd253, 1'b1, 8'd80));
      // Just below the invert threshold: recirculate the top bit
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd149, 1'b1, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncClock, 1'b0, 8'd150, 1'b1, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd150, 1'b0, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncClock, 1'b1, 8'd163, 1'b1, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncTick,  1'b0, 8'd163, 1'b0, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncTick,  1'b1, 8'd0,   1'b1, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncClock, 1'b0, 8'h55,  1'b0, 1'b0, '0, 1'b0, '0));
      dir_rows.push_back(mk_row(FuncTick,  1'b0, 8'hAA,  1'b1, 1'b0, '0, 1'b0, '0));

      // Phase 0 is all ticks, so the second wrap arms sync. Phase 1 runs
      // synced periods with sync restarts and square double steps. Phase 2
      // floods edges with no idling, past the disable point into saturation.
      // Phases 3 and 4 cover the extreme and crossed thresholds.
      phases.push_back(mk_phase(8'd162, 8'd150, 8'hA5, 560, 1000, 1000, 0,  1'b0));
      phases.push_back(mk_phase(8'd200, 8'd100, 8'h3C, 300, 50,   180,  5,  1'b0));
      phases.push_back(mk_phase(8'd0,   8'd0,   8'hFF, 100, 0,    3,    0,  1'b1));
      phases.push_back(mk_phase(8'd255, 8'd255, 8'h00, 100, 10,   60,   10, 1'b0));
      phases.push_back(mk_phase(8'd100, 8'd200, 8'h81, 100, 100,  250,  8,  1'b0));

      clear_model();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) begin
         send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
      end

      foreach (phases[p]) begin
         wait_drained();
         program_phase(phases[p]);
         steady_run = phases[p].steady;
         ticks_left = $urandom_range(phases[p].gap_hi, phases[p].gap_lo);
         rise_next  = 1'b0;
         for (int unsigned n = 0; n < phases[p].count; n++) begin
            item = req_payload_type'($urandom);
            item.bit_control = pick_control();
            if ($urandom_range(99) < phases[p].noise_pct) begin
               // Stray pin sample at a random level
               item.func = FuncClock;
            end else if (ticks_left != 0) begin
               item.func = FuncTick;
               ticks_left--;
            end else begin
               // Low then high sample: one clean rising edge
               item.func        = FuncClock;
               item.clock_level = rise_next;
               if (rise_next) begin
                  ticks_left = $urandom_range(phases[p].gap_hi, phases[p].gap_lo);
               end
               rise_next = ~rise_next;
            end
            send_item(item, 1'b0, no_result);
         end
         steady_run = 1'b0;
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
